// ----- hdl/pva_pkg.sv -----
`default_nettype none

package pva_pkg;

  // Voice pool size and index widths.
  localparam int VOICES  = 7;
  localparam int VOICE_W = 3;
  localparam int COUNT_W = 3;

  // MIDI status codes that cause work.
  localparam logic [7:0] STATUS_ON  = 8'd144;
  localparam logic [7:0] STATUS_OFF = 8'd128;

  // Voice command codes.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_MIN,
    ST_STEAL,
    ST_START,
    ST_SCAN_NOTE,
    ST_OFF
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic scan_clear;
    logic min_step;
    logic note_step;
    logic emit_steal;
    logic emit_start;
    logic emit_off;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic is_on;
    logic is_off;
    logic all_busy;
    logic scan_last;
    logic note_match;
    logic free_empty;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hdl/pva_msg_if.sv -----
`default_nettype none

interface pva_msg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  func;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [31:0] time_delta;

  modport source (output valid, func, note, velocity, time_delta, input ready);
  modport sink (input valid, func, note, velocity, time_delta, output ready);
endinterface

`default_nettype wire

// ----- hdl/pva_cmd_if.sv -----
`default_nettype none

interface pva_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [pva_pkg::VOICE_W-1:0] voice;
  logic                        command;
  logic [6:0]                  note_out;
  logic [6:0]                  velocity_out;
  logic                        last;

  modport source (output valid, voice, command, note_out, velocity_out, last, input ready);
  modport sink (input valid, voice, command, note_out, velocity_out, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/pva_ctrl.sv -----
`default_nettype none

module pva_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pva_pkg::dp_sts_t sts,
  output pva_pkg::dp_cmd_t      cmd
);

  pva_pkg::state_t state;
  pva_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pva_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      pva_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) begin
          cmd.scan_clear = 1'b1;
          if (sts.is_on) begin
            state_next = sts.all_busy ? pva_pkg::ST_SCAN_MIN : pva_pkg::ST_START;
          end else if (sts.is_off) begin
            state_next = pva_pkg::ST_SCAN_NOTE;
          end
        end
      end
      pva_pkg::ST_SCAN_MIN: begin
        cmd.min_step = 1'b1;
        if (sts.scan_last) begin
          state_next = pva_pkg::ST_STEAL;
        end
      end
      pva_pkg::ST_STEAL: begin
        if (sts.out_free) begin
          cmd.emit_steal = 1'b1;
          state_next     = pva_pkg::ST_START;
        end
      end
      pva_pkg::ST_START: begin
        if (sts.free_empty) begin
          state_next = pva_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_start = 1'b1;
          state_next     = pva_pkg::ST_IDLE;
        end
      end
      pva_pkg::ST_SCAN_NOTE: begin
        if (sts.note_match) begin
          state_next = pva_pkg::ST_OFF;
        end else if (sts.scan_last) begin
          state_next = pva_pkg::ST_IDLE;
        end else begin
          cmd.note_step = 1'b1;
        end
      end
      pva_pkg::ST_OFF: begin
        if (sts.out_free) begin
          cmd.emit_off = 1'b1;
          state_next   = pva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pva_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/pva_datapath.sv -----
`default_nettype none

module pva_datapath #(
  parameter int TIME_BITS = 48
) (
  input  wire logic             clk,
  input  wire logic             rst,
  pva_msg_if.sink               midi,
  pva_cmd_if.source             voice_cmd,
  input  wire pva_pkg::dp_cmd_t cmd,
  output pva_pkg::dp_sts_t      sts
);

  localparam int VW = pva_pkg::VOICE_W;
  localparam int CW = pva_pkg::COUNT_W;

  logic [TIME_BITS-1:0]         time_acc;
  logic [7:0]                   cur_func;
  logic [6:0]                   cur_note;
  logic [6:0]                   cur_vel;
  logic [pva_pkg::VOICES-1:0]   busy;
  logic [6:0]                   voice_note [pva_pkg::VOICES];
  logic [TIME_BITS-1:0]         voice_time [pva_pkg::VOICES];
  logic [VW-1:0]                free_list [pva_pkg::VOICES];
  logic [CW-1:0]                free_count;
  logic [VW-1:0]                scan_idx;
  logic [VW-1:0]                best_idx;
  logic [TIME_BITS-1:0]         best_time;
  logic [6:0]                   best_note;
  logic                         out_valid;
  logic                         accept;
  logic                         out_free;
  logic [VW-1:0]                pop_voice;
  logic                         take_min;

  assign accept    = cmd.take && midi.valid;
  assign midi.ready = cmd.take;
  assign out_free  = !out_valid || voice_cmd.ready;
  assign pop_voice = free_list[VW'(free_count - CW'(1))];
  assign take_min  = (scan_idx == '0) || (voice_time[scan_idx] < best_time);

  // Status toward the controller.
  always_comb begin
    sts.in_valid   = midi.valid;
    sts.is_on      = midi.func == pva_pkg::STATUS_ON;
    sts.is_off     = midi.func == pva_pkg::STATUS_OFF;
    sts.all_busy   = &busy;
    sts.scan_last  = scan_idx == VW'(pva_pkg::VOICES - 1);
    sts.note_match = busy[scan_idx] && (voice_note[scan_idx] == cur_note);
    sts.free_empty = free_count == '0;
    sts.out_free   = out_free;
  end

  // Message capture and the running time base.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_acc <= '0;
    end else if (accept) begin
      time_acc <= time_acc + TIME_BITS'(midi.time_delta);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_func <= midi.func;
      cur_note <= midi.note;
      cur_vel  <= midi.velocity;
    end
  end

  // Scan pointer and the running oldest-voice candidate.
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_idx <= '0;
    end else if (cmd.min_step || cmd.note_step) begin
      scan_idx <= scan_idx + VW'(1);
    end
    if (cmd.min_step && take_min) begin
      best_idx  <= scan_idx;
      best_time <= voice_time[scan_idx];
      best_note <= voice_note[scan_idx];
    end
  end

  // Voice table: busy flags, notes and start times.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (cmd.emit_steal) begin
      busy[best_idx] <= 1'b0;
    end else if (cmd.emit_off) begin
      busy[scan_idx] <= 1'b0;
    end else if (cmd.emit_start) begin
      busy[pop_voice] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      voice_note[pop_voice] <= cur_note;
      voice_time[pop_voice] <= time_acc;
    end
  end

  // Free list: push at the back on a steal, pop from the back on a start,
  // insert at the front on a note off.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pva_pkg::VOICES; i++) begin
        free_list[i] <= VW'(pva_pkg::VOICES - 1 - i);
      end
      free_count <= CW'(pva_pkg::VOICES);
    end else if (cmd.emit_steal) begin
      free_list[VW'(free_count)] <= best_idx;
      free_count                 <= free_count + CW'(1);
    end else if (cmd.emit_start) begin
      free_count <= free_count - CW'(1);
    end else if (cmd.emit_off) begin
      free_list[0] <= scan_idx;
      for (int i = 1; i < pva_pkg::VOICES; i++) begin
        free_list[i] <= free_list[i-1];
      end
      free_count <= free_count + CW'(1);
    end
  end

  // Output register; it holds a result until the sink takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_steal || cmd.emit_start || cmd.emit_off) begin
      out_valid <= 1'b1;
    end else if (voice_cmd.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_steal) begin
      voice_cmd.voice        <= best_idx;
      voice_cmd.command      <= pva_pkg::CMD_RELEASE;
      voice_cmd.note_out     <= best_note;
      voice_cmd.velocity_out <= '0;
      voice_cmd.last         <= 1'b0;
    end else if (cmd.emit_start) begin
      voice_cmd.voice        <= pop_voice;
      voice_cmd.command      <= pva_pkg::CMD_START;
      voice_cmd.note_out     <= cur_note;
      voice_cmd.velocity_out <= cur_vel;
      voice_cmd.last         <= 1'b1;
    end else if (cmd.emit_off) begin
      voice_cmd.voice        <= scan_idx;
      voice_cmd.command      <= pva_pkg::CMD_RELEASE;
      voice_cmd.note_out     <= cur_note;
      voice_cmd.velocity_out <= '0;
      voice_cmd.last         <= 1'b1;
    end
  end

  assign voice_cmd.valid = out_valid;

  // Every voice is either busy or on the free list.
  a_pool_conserved: assert property (@(posedge clk) disable iff (rst)
    ($countones(busy) + int'(free_count)) == pva_pkg::VOICES)
    else $error("busy voices and free list disagree");

  // A steal only happens with the whole pool busy, and for a note on.
  a_steal_full: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_steal |-> (&busy && cur_func == pva_pkg::STATUS_ON))
    else $error("steal issued with a free voice");

  // A start always pops a voice that was idle.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_start |-> (free_count != '0 && !busy[pop_voice]))
    else $error("start on a busy voice or empty free list");

  // A result is never loaded over one that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_steal || cmd.emit_start || cmd.emit_off) |-> out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire

// ----- hdl/poly_voice_allocator_oldest_steal_top.sv -----
// A note on with a free voice loads its start command into the output register from the start state.
// A note on with all voices busy scans the start times, one voice per cycle, and gives the
// release of the oldest voice, then the start once the output register is free again.
// A note off scans notes one voice per cycle until it finds the note or reaches the last voice.
// One message at a time; the output register lets a message be taken while a result waits.
// Reset (rst, synchronous): all voices idle, free list VOICES-1 down to 0, time base zero.
`default_nettype none

module poly_voice_allocator_oldest_steal_top #(
  parameter int TIME_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  pva_msg_if.sink   midi,
  pva_cmd_if.source voice_cmd
);

  pva_pkg::dp_cmd_t cmd;
  pva_pkg::dp_sts_t sts;

  pva_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  pva_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .midi      (midi),
    .voice_cmd (voice_cmd),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
